// ===== src/tart_pkg.sv =====
// ----------------------------------------------------------------------------
// tart_pkg
// Shared types and codes for the threshold alert rule table unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tart_pkg;

  localparam int MAX_RULES_DEF = 32;
  localparam int SLOT_W        = 8;
  localparam int QDEPTH        = 2;

  localparam logic FN_ADD  = 1'b0;
  localparam logic FN_EVAL = 1'b1;

  localparam logic [1:0] PH_OK      = 2'd0;
  localparam logic [1:0] PH_WAITING = 2'd1;
  localparam logic [1:0] PH_ALARM   = 2'd2;

  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_FIRED   = 2'd1;
  localparam logic [1:0] ST_CLEARED = 2'd2;
  localparam logic [1:0] ST_ERROR   = 2'd3;

  typedef enum logic [1:0] {
    K_ADD  = 2'd0,
    K_EVAL = 2'd1,
    K_ERR  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [SLOT_W-1:0]  slot;
    logic signed [31:0] sample_value;
    logic [63:0]        now_ms;
    logic signed [31:0] threshold_value;
    logic               above_mode;
    logic [30:0]        hold_ms;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] assigned_index;
    logic [1:0] rule_state;
    logic [5:0] firing_count;
  } res_t;

endpackage

`default_nettype wire

// ===== src/tart_front.sv =====
// ----------------------------------------------------------------------------
// tart_front
// Accepts items, tracks the rule count and classifies each item as add,
// evaluate or error before handing it on.
// ----------------------------------------------------------------------------
`default_nettype none

module tart_front #(
  parameter int MAX_RULES = tart_pkg::MAX_RULES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               func,
  input  wire logic [4:0]         rule_index,
  input  wire logic signed [31:0] sample_value,
  input  wire logic [63:0]        now_ms,
  input  wire logic signed [31:0] threshold_value,
  input  wire logic               above_mode,
  input  wire logic [30:0]        hold_ms,
  input  wire logic               q_full,
  output logic                    q_push,
  output tart_pkg::cmd_t          q_data
);

  localparam int CW   = $clog2(MAX_RULES + 1);
  localparam int CMPW = (CW > 5) ? CW : 5;

  logic [CW-1:0]   rules_in_use;
  logic [CMPW-1:0] idx_ext;
  logic [CMPW-1:0] cnt_ext;
  logic            full;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign full     = (rules_in_use == CW'(MAX_RULES));
  assign idx_ext  = CMPW'(rule_index);
  assign cnt_ext  = CMPW'(rules_in_use);

  always_comb begin
    q_data.sample_value    = sample_value;
    q_data.now_ms          = now_ms;
    q_data.threshold_value = threshold_value;
    q_data.above_mode      = above_mode;
    q_data.hold_ms         = hold_ms;
    q_data.slot            = '0;
    q_data.kind            = tart_pkg::K_ERR;
    if (func == tart_pkg::FN_ADD) begin
      if (!full) begin
        q_data.kind = tart_pkg::K_ADD;
        q_data.slot = tart_pkg::SLOT_W'(rules_in_use);
      end
    end else begin
      if (idx_ext < cnt_ext) begin
        q_data.kind = tart_pkg::K_EVAL;
        q_data.slot = tart_pkg::SLOT_W'(rule_index);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rules_in_use <= '0;
    end else if (q_push && func == tart_pkg::FN_ADD && !full) begin
      rules_in_use <= rules_in_use + CW'(1);
    end
  end

endmodule

`default_nettype wire

// ===== src/tart_queue.sv =====
// ----------------------------------------------------------------------------
// tart_queue
// Short command queue between the classifying front and the table back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tart_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire tart_pkg::cmd_t push_data,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output tart_pkg::cmd_t      head
);

  localparam int PW = (tart_pkg::QDEPTH > 1) ? $clog2(tart_pkg::QDEPTH) : 1;
  localparam int NW = $clog2(tart_pkg::QDEPTH + 1);

  tart_pkg::cmd_t mem [tart_pkg::QDEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [NW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full       = (count == NW'(tart_pkg::QDEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(tart_pkg::QDEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(tart_pkg::QDEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + NW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - NW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/tart_back.sv =====
// ----------------------------------------------------------------------------
// tart_back
// Rule table back end: reads the addressed entry, applies the alert state
// update, writes it back and holds the result for the output.
// ----------------------------------------------------------------------------
`default_nettype none

module tart_back #(
  parameter int MAX_RULES = tart_pkg::MAX_RULES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           head_valid,
  input  wire tart_pkg::cmd_t head,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output tart_pkg::res_t      out_res
);

  localparam int IW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CW = $clog2(MAX_RULES + 1);

  localparam logic BK_IDLE = 1'b0;
  localparam logic BK_EXEC = 1'b1;

  logic signed [31:0] thr_mem   [MAX_RULES];
  logic               above_mem [MAX_RULES];
  logic [30:0]        hold_mem  [MAX_RULES];
  logic [1:0]         phase_mem [MAX_RULES];
  logic [63:0]        since_mem [MAX_RULES];

  logic               state;
  tart_pkg::cmd_t     cmd;
  logic signed [31:0] rd_thr;
  logic               rd_above;
  logic [30:0]        rd_hold;
  logic [1:0]         rd_phase;
  logic [63:0]        rd_since;
  logic [CW-1:0]      firing_total;
  logic [CW-1:0]      firing_next;

  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;
  logic          out_free;
  logic          exec;
  logic          breached;
  logic [63:0]   elapsed;
  logic          hold_met;
  logic [1:0]    phase_next;
  logic [1:0]    status;
  logic          since_wr;
  logic          phase_wr;
  logic          rule_wr;

  assign rd_addr  = IW'(head.slot);
  assign wr_addr  = IW'(cmd.slot);
  assign out_free = !out_valid || out_ready;
  assign pop      = (state == BK_IDLE) && head_valid;
  assign exec     = (state == BK_EXEC) && out_free;
  assign elapsed  = cmd.now_ms - rd_since;
  assign hold_met = (elapsed >= 64'(rd_hold));
  assign breached = rd_above ? ($signed(cmd.sample_value) > $signed(rd_thr))
                             : ($signed(cmd.sample_value) < $signed(rd_thr));

  always_comb begin
    phase_next  = tart_pkg::PH_OK;
    status      = tart_pkg::ST_NONE;
    since_wr    = 1'b0;
    phase_wr    = 1'b0;
    rule_wr     = 1'b0;
    firing_next = firing_total;
    unique case (cmd.kind)
      tart_pkg::K_ADD: begin
        rule_wr  = 1'b1;
        phase_wr = 1'b1;
      end
      tart_pkg::K_EVAL: begin
        phase_wr   = 1'b1;
        phase_next = rd_phase;
        if (breached) begin
          if (rd_phase == tart_pkg::PH_OK) begin
            phase_next = tart_pkg::PH_WAITING;
            since_wr   = 1'b1;
          end else if (rd_phase == tart_pkg::PH_WAITING && hold_met) begin
            phase_next  = tart_pkg::PH_ALARM;
            firing_next = firing_total + CW'(1);
            status      = tart_pkg::ST_FIRED;
          end
        end else begin
          phase_next = tart_pkg::PH_OK;
          if (rd_phase == tart_pkg::PH_ALARM) begin
            status = tart_pkg::ST_CLEARED;
            if (firing_total != '0) begin
              firing_next = firing_total - CW'(1);
            end
          end
        end
      end
      default: begin
        status = tart_pkg::ST_ERROR;
      end
    endcase
  end

  // table storage, one registered read port and one write port per array
  always_ff @(posedge clk) begin
    if (pop) begin
      rd_thr   <= thr_mem[rd_addr];
      rd_above <= above_mem[rd_addr];
      rd_hold  <= hold_mem[rd_addr];
      rd_phase <= phase_mem[rd_addr];
      rd_since <= since_mem[rd_addr];
      cmd      <= head;
    end
    if (exec && rule_wr) begin
      thr_mem[wr_addr]   <= cmd.threshold_value;
      above_mem[wr_addr] <= cmd.above_mode;
      hold_mem[wr_addr]  <= cmd.hold_ms;
    end
    if (exec && phase_wr) begin
      phase_mem[wr_addr] <= phase_next;
    end
    if (exec && since_wr) begin
      since_mem[wr_addr] <= cmd.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_res.status         <= status;
      out_res.assigned_index <= (cmd.kind == tart_pkg::K_ADD) ? 5'(cmd.slot) : 5'd0;
      out_res.rule_state     <= phase_next;
      out_res.firing_count   <= 6'(firing_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_IDLE;
      out_valid    <= 1'b0;
      firing_total <= '0;
    end else begin
      if (exec) begin
        out_valid    <= 1'b1;
        firing_total <= firing_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        BK_IDLE: begin
          if (head_valid) begin
            state <= BK_EXEC;
          end
        end
        BK_EXEC: begin
          if (out_free) begin
            state <= BK_IDLE;
          end
        end
        default: begin
          state <= BK_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/threshold_alert_rule_table_unit.sv =====
// ----------------------------------------------------------------------------
// threshold_alert_rule_table_unit
// Table of threshold alert rules with hold time: add rules, evaluate samples.
// ----------------------------------------------------------------------------
// the back end takes a new item only once the table read and write-back of
// the previous rule entry are done; a 2-entry queue decouples the input
// reset: rule count, firing count, queue and output valid cleared at once;
// table contents are not cleared and are only used after being written
`default_nettype none

module threshold_alert_rule_table_unit #(
  parameter int MAX_RULES = tart_pkg::MAX_RULES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // rule_index, sample_value, now_ms, threshold_value, above_mode, hold_ms
  input  wire logic [167:0] s_tdata,
  // func
  input  wire logic [0:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // assigned_index, rule_state, firing_count
  output logic [15:0]       m_tdata,
  // status
  output logic [1:0]        m_tuser
);

  tart_pkg::cmd_t q_in;
  tart_pkg::cmd_t q_head;
  tart_pkg::res_t res;
  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_valid;

  tart_front #(
    .MAX_RULES(MAX_RULES)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s_tvalid),
    .in_ready        (s_tready),
    .func            (s_tuser[0]),
    .rule_index      (s_tdata[4:0]),
    .sample_value    ($signed(s_tdata[36:5])),
    .now_ms          (s_tdata[100:37]),
    .threshold_value ($signed(s_tdata[132:101])),
    .above_mode      (s_tdata[133]),
    .hold_ms         (s_tdata[164:134]),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_data          (q_in)
  );

  tart_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  tart_back #(
    .MAX_RULES(MAX_RULES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_res    (res)
  );

  assign m_tdata = {3'b000, res.firing_count, res.rule_state, res.assigned_index};
  assign m_tuser = res.status;

  a_err_fields : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == tart_pkg::ST_ERROR) |-> (m_tdata[6:0] == 7'd0))
    else $error("error result with non-zero index or state");

  a_fired_state : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == tart_pkg::ST_FIRED) |->
      (m_tdata[6:5] == tart_pkg::PH_ALARM && m_tdata[12:7] != 6'd0))
    else $error("fired result without firing state");

  a_cleared_state : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == tart_pkg::ST_CLEARED) |-> (m_tdata[6:5] == tart_pkg::PH_OK))
    else $error("cleared result with rule not ok");

  a_pop_paced : assert property (@(posedge clk) disable iff (rst)
    q_pop |=> !q_pop)
    else $error("back end popped on consecutive cycles");

endmodule

`default_nettype wire
